[rtl/sdbc_pkg.sv]
// sample dma buffer cache: shared types, status codes and link constants
// no dependencies
package sdbc_pkg;

  localparam int unsigned LinkW = 6;
  localparam logic [LinkW-1:0] LinkNil = 6'd63;

  localparam logic [1:0] StatHit    = 2'd0;
  localparam logic [1:0] StatMiss   = 2'd1;
  localparam logic [1:0] StatNoFree = 2'd2;
  localparam logic [1:0] StatTick   = 2'd3;

  typedef struct packed {
    logic        op;
    logic [31:0] rom_address;
    logic [15:0] byte_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  buffer_index;
    logic [9:0]  byte_offset;
    logic [31:0] fetch_address;
  } rsp_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load_req;   // capture request, start walk at used head
    logic step;       // advance cursor to the next link
    logic hit_mark;   // mark cursor with current frame
    logic miss_ins;   // take free head, link into used list
    logic tick_free;  // free the cursor buffer
    logic tick_done;  // increment frame count
    logic set_last;   // remember cursor as last walked
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic is_tick;
    logic cur_valid;
    logic stop_above;
    logic hit;
    logic stale;
    logic free_valid;
  } sts_t;

endpackage

[rtl/sdbc_ctrl.sv]
// sample dma buffer cache: controller walking the lists one entry per cycle unless a held result stalls the walk
// depends on sdbc_pkg
module sdbc_ctrl #(
  parameter int unsigned BufferCount = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             out_busy_i,
  input  sdbc_pkg::sts_t   sts_i,
  output sdbc_pkg::cmd_t   cmd_o,
  output logic             rsp_load_o,
  output logic [1:0]       rsp_kind_o
);

  localparam int unsigned StepW = $clog2(BufferCount + 1);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StWalk = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [StepW-1:0] steps_q, steps_d;

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d    = state_q;
    steps_d    = steps_q;
    cmd_o      = '0;
    rsp_load_o = 1'b0;
    rsp_kind_o = sdbc_pkg::StatTick;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          steps_d        = '0;
          state_d        = StWalk;
        end
      end
      StWalk: begin
        if (!out_busy_i) begin
          if (!sts_i.cur_valid || steps_q == StepW'(BufferCount)) begin
            if (sts_i.is_tick) begin
              cmd_o.tick_done = 1'b1;
              rsp_kind_o      = sdbc_pkg::StatTick;
            end else if (sts_i.free_valid) begin
              cmd_o.miss_ins = 1'b1;
              rsp_kind_o     = sdbc_pkg::StatMiss;
            end else begin
              rsp_kind_o = sdbc_pkg::StatNoFree;
            end
            rsp_load_o = 1'b1;
            state_d    = StDone;
          end else if (sts_i.is_tick) begin
            cmd_o.tick_free = sts_i.stale;
            cmd_o.step      = 1'b1;
            steps_d         = steps_q + 1'b1;
          end else if (sts_i.stop_above) begin
            if (sts_i.free_valid) begin
              cmd_o.miss_ins = 1'b1;
              rsp_kind_o     = sdbc_pkg::StatMiss;
            end else begin
              rsp_kind_o = sdbc_pkg::StatNoFree;
            end
            rsp_load_o = 1'b1;
            state_d    = StDone;
          end else if (sts_i.hit) begin
            cmd_o.hit_mark = 1'b1;
            rsp_kind_o     = sdbc_pkg::StatHit;
            rsp_load_o     = 1'b1;
            state_d        = StDone;
          end else begin
            cmd_o.set_last = 1'b1;
            cmd_o.step     = 1'b1;
            steps_d        = steps_q + 1'b1;
          end
        end
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      steps_q <= '0;
    end else begin
      state_q <= state_d;
      steps_q <= steps_d;
    end
  end

endmodule

[rtl/sdbc_dp.sv]
// sample dma buffer cache: link registers, per-buffer address and frame, result
// depends on sdbc_pkg
module sdbc_dp #(
  parameter int unsigned BufferCount = 32,
  parameter int unsigned BufferBytes = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sdbc_pkg::req_t   req_i,
  input  logic [3:0]       frame_lag_i,
  input  sdbc_pkg::cmd_t   cmd_i,
  input  logic             rsp_load_i,
  input  logic [1:0]       rsp_kind_i,
  output sdbc_pkg::sts_t   sts_o,
  output sdbc_pkg::rsp_t   rsp_o
);

  localparam int unsigned LW = sdbc_pkg::LinkW;
  localparam int unsigned IdxW = (BufferCount > 1) ? $clog2(BufferCount) : 1;
  localparam logic [LW-1:0] Nil = sdbc_pkg::LinkNil;

  logic [LW-1:0] next_q [BufferCount];
  logic [LW-1:0] prev_q [BufferCount];
  logic [31:0]   start_q [BufferCount];
  logic [31:0]   frame_of_q [BufferCount];
  logic [LW-1:0] used_head_q, free_head_q, cur_q, last_q;
  logic [31:0]   frame_count_q;
  sdbc_pkg::req_t req_q;
  sdbc_pkg::rsp_t rsp_d;

  function automatic logic ok(input logic [LW-1:0] i);
    ok = (i < LW'(BufferCount));
  endfunction

  logic [IdxW-1:0] cur_ix, free_ix, last_ix, used_ix;
  logic [31:0] s_cur;
  logic [32:0] want_end, buf_end;
  logic [LW-1:0] nxt_cur, fh_next;

  assign cur_ix   = cur_q[IdxW-1:0];
  assign free_ix  = free_head_q[IdxW-1:0];
  assign last_ix  = last_q[IdxW-1:0];
  assign used_ix  = used_head_q[IdxW-1:0];
  assign s_cur    = start_q[cur_ix];
  assign nxt_cur  = next_q[cur_ix];
  assign fh_next  = next_q[free_ix];
  assign want_end = {1'b0, req_q.rom_address} + 33'(req_q.byte_length);
  assign buf_end  = {1'b0, s_cur} + 33'(BufferBytes);

  assign sts_o.is_tick    = req_q.op;
  assign sts_o.cur_valid  = ok(cur_q);
  assign sts_o.stop_above = s_cur > req_q.rom_address;
  assign sts_o.hit        = want_end <= buf_end;
  assign sts_o.stale      = (frame_of_q[cur_ix] + 32'(frame_lag_i)) < frame_count_q;
  assign sts_o.free_valid = ok(free_head_q);

  logic [31:0] even_addr;
  assign even_addr = {req_q.rom_address[31:1], 1'b0};

  // link updates; lookup steps only move the cursor and last walked
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < BufferCount; i++) begin
        next_q[i] <= (i + 1 < BufferCount) ? LW'(i + 1) : Nil;
        prev_q[i] <= (i == 0) ? Nil : LW'(i - 1);
      end
      used_head_q   <= Nil;
      free_head_q   <= '0;
      frame_count_q <= '0;
      cur_q         <= Nil;
      last_q        <= Nil;
    end else begin
      if (cmd_i.load_req) begin
        cur_q  <= used_head_q;
        last_q <= Nil;
      end
      if (cmd_i.set_last) last_q <= cur_q;
      if (cmd_i.step) cur_q <= nxt_cur;
      if (cmd_i.tick_done) frame_count_q <= frame_count_q + 32'd1;
      if (cmd_i.tick_free) begin
        // unlink cur
        if (used_head_q == cur_q) used_head_q <= ok(nxt_cur) ? nxt_cur : Nil;
        if (ok(nxt_cur)) prev_q[nxt_cur[IdxW-1:0]] <= prev_q[cur_ix];
        if (ok(prev_q[cur_ix])) next_q[prev_q[cur_ix][IdxW-1:0]] <= nxt_cur;
        if (ok(free_head_q)) begin
          // cur sits after free head; prev link of old successor fixed up
          next_q[cur_ix] <= fh_next;
          prev_q[cur_ix] <= free_head_q;
          if (ok(fh_next)) prev_q[fh_next[IdxW-1:0]] <= cur_q;
          next_q[free_ix] <= cur_q;
        end else begin
          free_head_q    <= cur_q;
          next_q[cur_ix] <= Nil;
          prev_q[cur_ix] <= Nil;
        end
      end
      if (cmd_i.miss_ins) begin
        free_head_q <= ok(fh_next) ? fh_next : Nil;
        // free list head has no prev; unlink only fixes its successor
        if (ok(fh_next)) prev_q[fh_next[IdxW-1:0]] <= prev_q[free_ix];
        if (ok(prev_q[free_ix])) next_q[prev_q[free_ix][IdxW-1:0]] <= fh_next;
        if (ok(last_q)) begin
          next_q[free_ix] <= next_q[last_ix];
          prev_q[free_ix] <= last_q;
          if (ok(next_q[last_ix])) prev_q[next_q[last_ix][IdxW-1:0]] <= free_head_q;
          next_q[last_ix] <= free_head_q;
        end else if (ok(used_head_q)) begin
          used_head_q     <= free_head_q;
          next_q[free_ix] <= used_head_q;
          prev_q[free_ix] <= Nil;
          prev_q[used_ix] <= free_head_q;
        end else begin
          used_head_q     <= free_head_q;
          next_q[free_ix] <= Nil;
          prev_q[free_ix] <= Nil;
        end
      end
    end
  end

  always_comb begin
    rsp_d        = '0;
    rsp_d.status = rsp_kind_i;
    case (rsp_kind_i)
      sdbc_pkg::StatHit: begin
        rsp_d.buffer_index = 5'(cur_q);
        rsp_d.byte_offset  = 10'(req_q.rom_address - s_cur);
      end
      sdbc_pkg::StatMiss: begin
        rsp_d.buffer_index  = 5'(free_head_q);
        rsp_d.byte_offset   = 10'(req_q.rom_address[0]);
        rsp_d.fetch_address = even_addr;
      end
      sdbc_pkg::StatNoFree: begin
        rsp_d.buffer_index = ok(last_q) ? 5'(last_q) :
                             ok(used_head_q) ? 5'(used_head_q) : 5'd0;
        rsp_d.byte_offset  = 10'(req_q.rom_address[0]);
      end
      default: ;
    endcase
  end

  // payload stores, no reset
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) req_q <= req_i;
    if (cmd_i.hit_mark) frame_of_q[cur_ix] <= frame_count_q;
    if (cmd_i.miss_ins) begin
      start_q[free_ix]    <= even_addr;
      frame_of_q[free_ix] <= frame_count_q;
    end
    if (rsp_load_i) rsp_o <= rsp_d;
  end

endmodule

[rtl/sample_dma_buffer_cache.sv]
// sample dma buffer cache top: controller, datapath, output register
// result registered when the walk stops; a frame tick walks the whole used list;
// one list entry a cycle unless a held result stalls the walk
// one item in flight; the next is accepted after the done state returns to idle
// reset: empty used list, all buffers free in index order, frame count zero, lag 1
module sample_dma_buffer_cache #(
  parameter int unsigned BUFFER_COUNT = 32,
  parameter int unsigned BUFFER_BYTES = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  sdbc_pkg::req_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output sdbc_pkg::rsp_t   out_data_o,
  input  logic             cfg_we_i,
  input  logic [3:0]       cfg_data_i
);

  sdbc_pkg::cmd_t cmd;
  sdbc_pkg::sts_t sts;
  logic           rsp_load;
  logic [1:0]     rsp_kind;
  logic [3:0]     frame_lag_q;
  logic           out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_lag_q <= 4'd1;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) frame_lag_q <= cfg_data_i;
      if (rsp_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  sdbc_ctrl #(.BufferCount(BUFFER_COUNT)) u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o,
    .out_busy_i (out_valid_q && !out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .rsp_load_o (rsp_load),
    .rsp_kind_o (rsp_kind)
  );

  sdbc_dp #(.BufferCount(BUFFER_COUNT), .BufferBytes(BUFFER_BYTES)) u_dp (
    .clk_i, .rst_ni,
    .req_i       (in_data_i),
    .frame_lag_i (frame_lag_q),
    .cmd_i       (cmd),
    .rsp_load_i  (rsp_load),
    .rsp_kind_i  (rsp_kind),
    .sts_o       (sts),
    .rsp_o       (out_data_o)
  );

endmodule

[tb/sv/sample_dma_buffer_cache_tb.sv]
// testbench for the sample dma buffer cache: directed and random lookups and frame ticks
// against a behavioural model of the buffer lists; depends on sdbc_pkg and the top
module sample_dma_buffer_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBUF = 32;
  localparam int unsigned BUFB = 1024;
  localparam int unsigned WDOG_LIMIT = 20000;

  class buffer_cache_sb;
    logic [31:0] start_addr [NBUF];
    logic [31:0] used_frame [NBUF];
    logic [5:0]  nxt [NBUF];
    logic [5:0]  prv [NBUF];
    logic [5:0]  used_hd, free_hd;
    logic [31:0] frame_cnt;
    logic [3:0]  lag;
    sdbc_pkg::rsp_t pending [$];
    int          errors;
    int          hits, misses, nofree;

    function new();
      for (int i = 0; i < NBUF; i++) begin
        start_addr[i] = '0;
        used_frame[i] = '0;
        nxt[i] = (i + 1 < NBUF) ? 6'(i + 1) : sdbc_pkg::LinkNil;
        prv[i] = (i == 0) ? sdbc_pkg::LinkNil : 6'(i - 1);
      end
      used_hd = sdbc_pkg::LinkNil;
      free_hd = '0;
      frame_cnt = '0;
      lag = 4'd1;
      errors = 0;
    endfunction

    function bit ok(logic [5:0] i);
      return i < NBUF;
    endfunction

    function void detach(logic [5:0] n);
      logic [5:0] p, x;
      p = prv[n];
      x = nxt[n];
      if (ok(x)) prv[x] = p;
      if (ok(p)) nxt[p] = x;
    endfunction

    function void insert_after(logic [5:0] n, logic [5:0] t);
      logic [5:0] x;
      x = nxt[t];
      nxt[n] = x;
      prv[n] = t;
      if (ok(x)) prv[x] = n;
      nxt[t] = n;
    endfunction

    function sdbc_pkg::rsp_t age_buffers();
      logic [5:0] cur, nx;
      int steps;
      sdbc_pkg::rsp_t r;
      cur = used_hd;
      steps = 0;
      while (ok(cur) && steps < NBUF) begin
        nx = nxt[cur];
        steps++;
        if (32'(used_frame[cur] + 32'(lag)) < frame_cnt) begin
          if (used_hd == cur) used_hd = ok(nx) ? nx : sdbc_pkg::LinkNil;
          detach(cur);
          if (ok(free_hd)) begin
            insert_after(cur, free_hd);
          end else begin
            free_hd = cur;
            nxt[cur] = sdbc_pkg::LinkNil;
            prv[cur] = sdbc_pkg::LinkNil;
          end
        end
        cur = nx;
      end
      frame_cnt++;
      r = '0;
      r.status = sdbc_pkg::StatTick;
      return r;
    endfunction

    function sdbc_pkg::rsp_t find_samples(logic [31:0] addr, logic [15:0] len);
      logic [5:0] cur, last, n, old;
      logic [32:0] want_end;
      logic [31:0] s, even;
      int steps;
      sdbc_pkg::rsp_t r;
      r = '0;
      want_end = 33'(addr) + 33'(len);
      even = {addr[31:1], 1'b0};
      cur = used_hd;
      last = sdbc_pkg::LinkNil;
      steps = 0;
      while (ok(cur) && steps < NBUF) begin
        s = start_addr[cur];
        steps++;
        if (s > addr) break;
        if (want_end <= 33'(s) + 33'(BUFB)) begin
          used_frame[cur] = frame_cnt;
          r.status = sdbc_pkg::StatHit;
          r.buffer_index = cur[4:0];
          r.byte_offset = 10'(addr - s);
          hits++;
          return r;
        end
        last = cur;
        cur = nxt[cur];
      end
      n = free_hd;
      if (!ok(n)) begin
        if (!ok(last)) last = used_hd;
        if (!ok(last)) last = '0;
        r.status = sdbc_pkg::StatNoFree;
        r.buffer_index = last[4:0];
        r.byte_offset = {9'd0, addr[0]};
        nofree++;
        return r;
      end
      free_hd = ok(nxt[n]) ? nxt[n] : sdbc_pkg::LinkNil;
      detach(n);
      if (ok(last)) begin
        insert_after(n, last);
      end else if (ok(used_hd)) begin
        old = used_hd;
        used_hd = n;
        nxt[n] = old;
        prv[n] = sdbc_pkg::LinkNil;
        prv[old] = n;
      end else begin
        used_hd = n;
        nxt[n] = sdbc_pkg::LinkNil;
        prv[n] = sdbc_pkg::LinkNil;
      end
      start_addr[n] = even;
      used_frame[n] = frame_cnt;
      r.status = sdbc_pkg::StatMiss;
      r.buffer_index = n[4:0];
      r.byte_offset = {9'd0, addr[0]};
      r.fetch_address = even;
      misses++;
      return r;
    endfunction

    function void note_request(sdbc_pkg::req_t q);
      pending.push_back(q.op ? age_buffers() : find_samples(q.rom_address, q.byte_length));
    endfunction

    function void check_response(sdbc_pkg::rsp_t got);
      sdbc_pkg::rsp_t exp;
      if (pending.size() == 0) begin
        $display("%0t: unexpected response %p", $time, got);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status)
        $display("%0t: status exp %0d got %0d", $time, exp.status, got.status);
      if (got.buffer_index !== exp.buffer_index)
        $display("%0t: buffer_index exp %0d got %0d", $time, exp.buffer_index,
                 got.buffer_index);
      if (got.byte_offset !== exp.byte_offset)
        $display("%0t: byte_offset exp %0d got %0d", $time, exp.byte_offset,
                 got.byte_offset);
      if (got.fetch_address !== exp.fetch_address)
        $display("%0t: fetch_address exp %h got %h", $time, exp.fetch_address,
                 got.fetch_address);
      if (got !== exp) errors++;
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready, cfg_we;
  logic [3:0] cfg_data;
  sdbc_pkg::req_t in_data;
  sdbc_pkg::rsp_t out_data;
  buffer_cache_sb sb;
  int idle_cnt;
  bit long_hold;
  bit rx_free;

  sample_dma_buffer_cache dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .cfg_we_i(cfg_we), .cfg_data_i(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // valid drops only while idling, so back-to-back beats keep it high
  task automatic send_beat(sdbc_pkg::req_t q);
    int gap;
    gap = $urandom_range(0, 11);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q);
  endtask

  task automatic lookup(logic [31:0] a, logic [15:0] l);
    sdbc_pkg::req_t q;
    q.op = 1'b0;
    q.rom_address = a;
    q.byte_length = l;
    send_beat(q);
  endtask

  task automatic tick();
    sdbc_pkg::req_t q;
    q.op = 1'b1;
    q.rom_address = $urandom;
    q.byte_length = 16'($urandom);
    send_beat(q);
  endtask

  task automatic drain_and_set_lag(logic [3:0] v);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NBUF + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.lag = v;
  endtask

  // receiver: random stalls, with one long hold-off to back up the block
  initial begin
    int wait_cyc;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      wait_cyc = rx_free ? 0 : $urandom_range(0, 11);
      if (wait_cyc != 0) begin
        out_ready <= 1'b0;
        repeat (wait_cyc) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) sb.check_response(out_data);
    end
  end

  // watchdog on cycles without any accepted beat
  initial begin
    idle_cnt = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cnt = 0;
      else idle_cnt++;
      if (idle_cnt >= WDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [31:0] base;
    logic [31:0] a;
    sb = new();
    long_hold = 1'b0;
    rx_free = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_data = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, hit, miss, odd address, oversized length, tick
    lookup(32'hFFFF_FFFF, 16'hFFFF);
    lookup(32'h0000_0000, 16'h0000);
    lookup(32'h0000_0001, 16'd1023);
    lookup(32'h0000_0003, 16'd1021);
    lookup(32'h0000_0000, 16'd1024);
    lookup(32'h0000_1001, 16'd4);
    lookup(32'h0000_1100, 16'd2000);
    lookup(32'hFFFF_FC00, 16'd1024);
    lookup(32'hFFFF_FFFE, 16'd2);
    tick();
    tick();
    tick();
    tick();
    // fill every buffer then overflow
    for (int i = 0; i < 36; i++) lookup(32'h0010_0000 + 32'(i) * 32'h800, 16'd8);
    lookup(32'h0000_0005, 16'd8);
    tick();

    // lag extremes, small values and a random one, each with a random phase; first phase under back-pressure
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: drain_and_set_lag(4'd0);
        1: drain_and_set_lag(4'd15);
        2: drain_and_set_lag(4'd3);
        3: drain_and_set_lag(4'd1);
        default: drain_and_set_lag(4'($urandom_range(0, 15)));
      endcase
      if (ph == 0) long_hold = 1'b1;
      rx_free = (ph == 2);
      base = $urandom;
      for (int n = 0; n < 240; n++) begin
        case ($urandom_range(0, 9))
          0: tick();
          1: lookup($urandom, 16'($urandom));
          2, 3: lookup(base + 32'($urandom_range(0, 40 * 1024)), 16'($urandom_range(0, 1025)));
          default: begin
            // revisit a recently fetched region so that hits dominate
            a = base + 32'($urandom_range(0, 12)) * 32'd1024 + 32'($urandom_range(0, 1023));
            lookup(a, 16'($urandom_range(0, 64)));
          end
        endcase
      end
    end
    rx_free = 1'b0;
    in_valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (NBUF + 8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sdbc_pkg.sv
rtl/sdbc_ctrl.sv
rtl/sdbc_dp.sv
rtl/sample_dma_buffer_cache.sv
tb/sv/sample_dma_buffer_cache_tb.sv
